FILE: hw/rtl/gpq_pkg.sv
// Shared constants, codes and types of the gait phase qualifier.
package gpq_pkg;

	// Sample, run counter, configuration, minimum, count and index widths.
	localparam int SAMPLE_W = 16;
	localparam int RUN_W    = 8;
	localparam int CFG_W    = 15;
	localparam int MIN_W    = 8;
	localparam int COUNT_W  = 16;
	localparam int INDEX_W  = 3;

	// Width that holds the distance of a sample from the gravity reference.
	localparam int DIFF_W = ((SAMPLE_W > CFG_W) ? SAMPLE_W : CFG_W + 1) + 1;
	// Width in which a run length is compared with its minimum.
	localparam int RCMP_W = (RUN_W > MIN_W) ? RUN_W : MIN_W;

	localparam logic [RUN_W-1:0]   RUN_MAX   = {RUN_W{1'b1}};
	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

	// Configuration register indexes.
	localparam logic [INDEX_W-1:0] REG_ACCEL_BAND  = 3'd0;
	localparam logic [INDEX_W-1:0] REG_GYRO_BAND   = 3'd1;
	localparam logic [INDEX_W-1:0] REG_GRAVITY_REF = 3'd2;
	localparam logic [INDEX_W-1:0] REG_STANCE_MIN  = 3'd3;
	localparam logic [INDEX_W-1:0] REG_SWING_MIN   = 3'd4;

	// Register values after reset.
	localparam logic [CFG_W-1:0] ACCEL_BAND_RST  = 15'd256;
	localparam logic [CFG_W-1:0] GYRO_BAND_RST   = 15'd128;
	localparam logic [CFG_W-1:0] GRAVITY_REF_RST = 15'd2511;
	localparam logic [MIN_W-1:0] STANCE_MIN_RST  = 8'd3;
	localparam logic [MIN_W-1:0] SWING_MIN_RST   = 8'd3;

	// Item commands.
	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_CLEAR  = 1'b1;

	// Gait phase codes.
	localparam logic PHASE_STANCE = 1'b0;
	localparam logic PHASE_SWING  = 1'b1;

	// Classification thresholds.
	typedef struct packed {
		logic [CFG_W-1:0] accel_band;
		logic [CFG_W-1:0] gyro_band;
		logic [CFG_W-1:0] gravity_ref;
	} band_cfg_t;

	// Control handed from the input stage to the phase tracker.
	typedef struct packed {
		logic fire;
		logic clear;
		logic raw_stance;
	} trk_ctrl_t;

endpackage

FILE: hw/rtl/gait_phase_qualifier.sv
// Top level of the gait phase qualifier: configuration, input register and handshakes.
// One item is accepted per clock cycle while no held result stalls the input register:
// an input register holds the sample, and when it moves on the band compares and the run,
// phase and transition counter updates are done in one step into the result register.
// The figure of one item per cycle is set by that one-step state update, which each
// item needs before the next. A held result stalls the input register only once it is
// full. A clear item resets the run, phase and count state, giving stance and a zero count.
// Configuration registers are written through the cfg channel, which is always ready;
// writes should be made only while no item is in flight.
module gait_phase_qualifier (
	input  logic                          clk,
	input  logic                          arst_n,
	// Configuration write channel.
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [gpq_pkg::INDEX_W-1:0]   cfg_index,
	input  logic [gpq_pkg::CFG_W-1:0]     cfg_data,
	// Sample stream.
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [2*gpq_pkg::SAMPLE_W-1:0] s_axis_tdata, // accel_vert, pitch_rate
	input  logic [0:0]                    s_axis_tuser, // command
	// Result stream.
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [23:0]                   m_axis_tdata  // phase, transition_total, zero pad
);
	import gpq_pkg::*;

	band_cfg_t          band_q;
	logic [MIN_W-1:0]   stance_min_q;
	logic [MIN_W-1:0]   swing_min_q;

	logic                       s1_valid_q;
	logic                       cmd_s1;
	logic signed [SAMPLE_W-1:0] accel_s1;
	logic signed [SAMPLE_W-1:0] rate_s1;
	logic                       out_valid_q;

	logic               advance;
	logic               raw_stance;
	trk_ctrl_t          ctrl;
	logic               phase;
	logic [COUNT_W-1:0] transition_total;

	// Configuration registers.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			band_q.accel_band  <= ACCEL_BAND_RST;
			band_q.gyro_band   <= GYRO_BAND_RST;
			band_q.gravity_ref <= GRAVITY_REF_RST;
			stance_min_q       <= STANCE_MIN_RST;
			swing_min_q        <= SWING_MIN_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_ACCEL_BAND:  band_q.accel_band  <= cfg_data;
				REG_GYRO_BAND:   band_q.gyro_band   <= cfg_data;
				REG_GRAVITY_REF: band_q.gravity_ref <= cfg_data;
				REG_STANCE_MIN:  stance_min_q       <= cfg_data[MIN_W-1:0];
				REG_SWING_MIN:   swing_min_q        <= cfg_data[MIN_W-1:0];
				default: ;
			endcase
		end
	end

	// Handshake: the input register moves on whenever the result register can take it.
	assign advance       = s1_valid_q && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !s1_valid_q || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_axis_tready) begin
				s1_valid_q <= s_axis_tvalid;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Input register payload.
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			cmd_s1   <= s_axis_tuser[0];
			accel_s1 <= s_axis_tdata[SAMPLE_W-1:0];
			rate_s1  <= s_axis_tdata[2*SAMPLE_W-1:SAMPLE_W];
		end
	end

	gpq_classify u_classify (
		.cfg        (band_q),
		.accel_vert (accel_s1),
		.pitch_rate (rate_s1),
		.raw_stance (raw_stance)
	);

	assign ctrl.fire       = advance;
	assign ctrl.clear      = (cmd_s1 == CMD_CLEAR);
	assign ctrl.raw_stance = raw_stance;

	gpq_tracker u_tracker (
		.clk              (clk),
		.arst_n           (arst_n),
		.ctrl             (ctrl),
		.stance_min       (stance_min_q),
		.swing_min        (swing_min_q),
		.phase            (phase),
		.transition_total (transition_total)
	);

	// Result stream.
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'd0, transition_total, phase};

`ifndef ASSERT_OFF
	// A clear item leaves stance and a zero count.
	a_clear_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance && cmd_s1 == CMD_CLEAR |=> phase == PHASE_STANCE && transition_total == '0)
		else $error("clear item did not reset the result");

	// The transition count never falls on a processed sample.
	a_count_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		advance && cmd_s1 == CMD_SAMPLE |=> transition_total >= $past(transition_total))
		else $error("transition count fell on a sample item");

	// The count moves exactly when the phase changes, unless it has saturated.
	a_count_tracks_phase: assert property (@(posedge clk) disable iff (!arst_n)
		advance && cmd_s1 == CMD_SAMPLE |=>
		((phase != $past(phase)) == (transition_total != $past(transition_total))) ||
		($past(transition_total) == COUNT_MAX))
		else $error("transition count out of step with phase");

	// A full input register waits while a result is held back.
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && out_valid_q && !m_axis_tready |-> !s_axis_tready && !advance)
		else $error("item accepted over a stalled result");
`endif

endmodule

FILE: hw/rtl/gpq_classify.sv
// Raw stance or swing decision for one inertial sample.
module gpq_classify (
	input  gpq_pkg::band_cfg_t               cfg,
	input  logic signed [gpq_pkg::SAMPLE_W-1:0] accel_vert,
	input  logic signed [gpq_pkg::SAMPLE_W-1:0] pitch_rate,
	output logic                             raw_stance
);
	import gpq_pkg::*;

	logic signed [DIFF_W-1:0] accel_diff;
	logic        [DIFF_W-1:0] accel_mag;
	logic        [SAMPLE_W-1:0] rate_mag;
	logic                     accel_ok;
	logic                     rate_ok;

	// Distance of the acceleration from gravity, exact in Q8.8.
	always_comb begin
		accel_diff = DIFF_W'(accel_vert) - DIFF_W'($signed({1'b0, cfg.gravity_ref}));
		accel_mag  = accel_diff[DIFF_W-1] ? DIFF_W'(-accel_diff) : DIFF_W'(accel_diff);
		rate_mag   = pitch_rate[SAMPLE_W-1] ? SAMPLE_W'(-pitch_rate) : SAMPLE_W'(pitch_rate);
	end

	// Both magnitudes must lie strictly inside their bands.
	assign accel_ok   = accel_mag < DIFF_W'(cfg.accel_band);
	assign rate_ok    = DIFF_W'(rate_mag) < DIFF_W'(cfg.gyro_band);
	assign raw_stance = accel_ok && rate_ok;

endmodule

FILE: hw/rtl/gpq_tracker.sv
// Run counters, confirmed phase and transition counter; the latter two form the result.
module gpq_tracker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  gpq_pkg::trk_ctrl_t            ctrl,
	input  logic [gpq_pkg::MIN_W-1:0]     stance_min,
	input  logic [gpq_pkg::MIN_W-1:0]     swing_min,
	output logic                          phase,
	output logic [gpq_pkg::COUNT_W-1:0]   transition_total
);
	import gpq_pkg::*;

	logic [RUN_W-1:0]   stance_run_q;
	logic [RUN_W-1:0]   swing_run_q;
	logic               phase_q;
	logic [COUNT_W-1:0] count_q;

	logic [RUN_W-1:0]   stance_run_d;
	logic [RUN_W-1:0]   swing_run_d;
	logic               phase_d;
	logic [COUNT_W-1:0] count_d;
	logic               confirm;
	logic               target;

	// Next state for one processed item.
	always_comb begin
		stance_run_d = stance_run_q;
		swing_run_d  = swing_run_q;
		confirm      = 1'b0;
		target       = PHASE_STANCE;
		if (ctrl.raw_stance) begin
			stance_run_d = (stance_run_q == RUN_MAX) ? RUN_MAX : stance_run_q + 1'b1;
			swing_run_d  = '0;
			confirm      = RCMP_W'(stance_run_d) > RCMP_W'(stance_min);
			target       = PHASE_STANCE;
		end else begin
			swing_run_d  = (swing_run_q == RUN_MAX) ? RUN_MAX : swing_run_q + 1'b1;
			stance_run_d = '0;
			confirm      = RCMP_W'(swing_run_d) > RCMP_W'(swing_min);
			target       = PHASE_SWING;
		end
		phase_d = phase_q;
		count_d = count_q;
		if (confirm) begin
			phase_d = target;
			if (phase_q != target && count_q != COUNT_MAX) begin
				count_d = count_q + 1'b1;
			end
		end
	end

	// State update when an item leaves the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stance_run_q <= '0;
			swing_run_q  <= '0;
			phase_q      <= PHASE_STANCE;
			count_q      <= '0;
		end else if (ctrl.fire) begin
			if (ctrl.clear) begin
				stance_run_q <= '0;
				swing_run_q  <= '0;
				phase_q      <= PHASE_STANCE;
				count_q      <= '0;
			end else begin
				stance_run_q <= stance_run_d;
				swing_run_q  <= swing_run_d;
				phase_q      <= phase_d;
				count_q      <= count_d;
			end
		end
	end

	assign phase            = phase_q;
	assign transition_total = count_q;

endmodule

FILE: verif/gpq_checker.sv
// Checker of the gait phase qualifier: watches every channel, predicts each result and compares.
module gpq_checker
	import gpq_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_valid,
	input  logic                    cfg_ready,
	input  logic [INDEX_W-1:0]      cfg_index,
	input  logic [CFG_W-1:0]        cfg_data,
	input  logic                    s_axis_tvalid,
	input  logic                    s_axis_tready,
	input  logic [2*SAMPLE_W-1:0]   s_axis_tdata, // accel_vert, pitch_rate
	input  logic [0:0]              s_axis_tuser, // command
	input  logic                    m_axis_tvalid,
	input  logic                    m_axis_tready,
	input  logic [23:0]             m_axis_tdata, // phase, transition_total, zero pad
	output int                      failures,
	output int                      pending
);
	timeunit 1ns;
	timeprecision 1ps;

	// One result item as the block should deliver it.
	typedef struct packed {
		logic               phase;
		logic [COUNT_W-1:0] total;
	} gait_result_t;

	gait_result_t awaited[$];

	// Own copy of the thresholds and of the tracker state.
	band_cfg_t          bands;
	logic [MIN_W-1:0]   stance_floor;
	logic [MIN_W-1:0]   swing_floor;
	logic [RUN_W-1:0]   stance_len;
	logic [RUN_W-1:0]   swing_len;
	logic               phase_now;
	logic [COUNT_W-1:0] changes;

	// A sample is stance when both distances lie strictly inside their bands.
	function automatic logic sample_at_rest(input logic signed [SAMPLE_W-1:0] accel,
			input logic signed [SAMPLE_W-1:0] rate);
		logic signed [SAMPLE_W+2:0] accel_gap;
		logic signed [SAMPLE_W+2:0] spin;
		accel_gap = accel - $signed({1'b0, bands.gravity_ref});
		if (accel_gap < 0) accel_gap = -accel_gap;
		spin = rate;
		if (spin < 0) spin = -spin;
		return accel_gap < $signed({1'b0, bands.accel_band}) &&
			spin < $signed({1'b0, bands.gyro_band});
	endfunction

	// Confirming the phase already held is not a transition; the count sticks at its top.
	function automatic void settle_phase(input logic target);
		if (phase_now != target && changes != COUNT_MAX) changes++;
		phase_now = target;
	endfunction

	// Moves the tracker on by one item and returns the phase and count it leaves.
	function automatic gait_result_t advance_gait(input logic cmd,
			input logic [SAMPLE_W-1:0] accel, input logic [SAMPLE_W-1:0] rate);
		if (cmd == CMD_CLEAR) begin
			stance_len = '0;
			swing_len  = '0;
			phase_now  = PHASE_STANCE;
			changes    = '0;
		end else if (sample_at_rest(accel, rate)) begin
			if (stance_len != RUN_MAX) stance_len++;
			swing_len = '0;
			if (stance_len > stance_floor) settle_phase(PHASE_STANCE);
		end else begin
			if (swing_len != RUN_MAX) swing_len++;
			stance_len = '0;
			if (swing_len > swing_floor) settle_phase(PHASE_SWING);
		end
		return {phase_now, changes};
	endfunction

	always @(posedge clk or negedge arst_n) begin
		gait_result_t want;
		if (!arst_n) begin
			bands.accel_band  = ACCEL_BAND_RST;
			bands.gyro_band   = GYRO_BAND_RST;
			bands.gravity_ref = GRAVITY_REF_RST;
			stance_floor      = STANCE_MIN_RST;
			swing_floor       = SWING_MIN_RST;
			stance_len        = '0;
			swing_len         = '0;
			phase_now         = PHASE_STANCE;
			changes           = '0;
			awaited.delete();
			pending  = 0;
			failures = 0;
		end else begin
			// Results are taken first, so an item accepted at this edge cannot cover a missing one.
			if (m_axis_tvalid && m_axis_tready) begin
				if (awaited.size() == 0) begin
					$error("result item with none awaited: tdata %h", m_axis_tdata);
					failures++;
				end else begin
					want = awaited.pop_front();
					if (m_axis_tdata[0] !== want.phase) begin
						$error("phase: expected %0d, actual %0d", want.phase, m_axis_tdata[0]);
						failures++;
					end
					if (m_axis_tdata[COUNT_W:1] !== want.total) begin
						$error("transition_total: expected %0d, actual %0d", want.total,
							m_axis_tdata[COUNT_W:1]);
						failures++;
					end
					if (m_axis_tdata[23:COUNT_W+1] !== '0) begin
						$error("zero pad: expected 0, actual %h", m_axis_tdata[23:COUNT_W+1]);
						failures++;
					end
				end
			end

			// Register writes; an unmapped index changes nothing.
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_ACCEL_BAND: bands.accel_band = cfg_data;
					REG_GYRO_BAND: bands.gyro_band = cfg_data;
					REG_GRAVITY_REF: bands.gravity_ref = cfg_data;
					REG_STANCE_MIN: stance_floor = cfg_data[MIN_W-1:0];
					REG_SWING_MIN: swing_floor = cfg_data[MIN_W-1:0];
					default: ;
				endcase
			end

			// Every accepted item yields exactly one result.
			if (s_axis_tvalid && s_axis_tready)
				awaited.push_back(advance_gait(s_axis_tuser[0], s_axis_tdata[SAMPLE_W-1:0],
					s_axis_tdata[2*SAMPLE_W-1:SAMPLE_W]));

			pending = awaited.size();
		end
	end

endmodule

FILE: verif/tb_gait_phase_qualifier.sv
// Testbench top of the gait phase qualifier: clock, reset, stimulus and verdict.
module tb_gait_phase_qualifier
	import gpq_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SAMPLE_HI = 2 ** (SAMPLE_W - 1) - 1;
	localparam int SAMPLE_LO = -(2 ** (SAMPLE_W - 1));
	localparam int G_RST     = int'(GRAVITY_REF_RST);
	localparam int A_RST     = int'(ACCEL_BAND_RST);
	localparam int R_RST     = int'(GYRO_BAND_RST);

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [INDEX_W-1:0]    cfg_index;
	logic [CFG_W-1:0]      cfg_data;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [2*SAMPLE_W-1:0] s_axis_tdata; // accel_vert, pitch_rate
	logic [0:0]            s_axis_tuser; // command
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [23:0]           m_axis_tdata; // phase, transition_total, zero pad
	int                    failures;
	int                    pending;
	logic                  steady;

	// Settings in force, used only to shape the samples.
	logic [CFG_W-1:0] cur_ab;
	logic [CFG_W-1:0] cur_gb;
	logic [CFG_W-1:0] cur_gr;
	logic [MIN_W-1:0] cur_smin;
	logic [MIN_W-1:0] cur_wmin;

	gait_phase_qualifier dut (.*);

	gpq_checker checker_inst (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// The result side stalls at random unless a steady stretch is running.
	always @(posedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= steady || ($urandom_range(99) >= 18);
		end
	end

	// Sends one item, after a random number of idle cycles.
	task automatic send_sample(input logic cmd, input logic [SAMPLE_W-1:0] accel,
			input logic [SAMPLE_W-1:0] rate);
		while (!steady && $urandom_range(99) < 18) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= cmd;
		s_axis_tdata  <= {rate, accel};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	task automatic probe(input int accel, input int rate);
		send_sample(CMD_SAMPLE, SAMPLE_W'(accel), SAMPLE_W'(rate));
	endtask

	// A value inside the band around the centre, or just outside it now and then far off.
	function automatic logic [SAMPLE_W-1:0] near(input int centre, input int band,
			input logic in_band);
		int off;
		int v;
		if (in_band) begin
			off = (band > 0) ? int'($urandom_range(0, 2 * band - 2)) - (band - 1) : 0;
		end else begin
			off = band + (($urandom_range(3) == 0) ? int'($urandom_range(0, 40000))
				: int'($urandom_range(0, 3)));
			if ($urandom_range(1)) off = -off;
		end
		v = centre + off;
		if (v > SAMPLE_HI) v = SAMPLE_HI;
		if (v < SAMPLE_LO) v = SAMPLE_LO;
		return SAMPLE_W'(v);
	endfunction

	// A sample meant to fall on one side of the classification.
	task automatic send_shaped(input logic want_stance);
		logic [SAMPLE_W-1:0] accel;
		logic [SAMPLE_W-1:0] rate;
		int                  miss;
		miss  = $urandom_range(2);
		accel = near(int'(cur_gr), int'(cur_ab), want_stance || miss == 1);
		rate  = near(0, int'(cur_gb), want_stance || miss == 0);
		send_sample(CMD_SAMPLE, accel, rate);
	endtask

	// Waits until every result has come back; the count is read away from the active edge.
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		@(posedge clk);
	endtask

	task automatic write_reg(input logic [INDEX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	// Writes all registers with the block idle, then pokes an unmapped index.
	task automatic load_settings(input logic [CFG_W-1:0] ab, input logic [CFG_W-1:0] gb,
			input logic [CFG_W-1:0] gr, input logic [MIN_W-1:0] smin,
			input logic [MIN_W-1:0] wmin);
		drain();
		write_reg(REG_ACCEL_BAND, ab);
		write_reg(REG_GYRO_BAND, gb);
		write_reg(REG_GRAVITY_REF, gr);
		write_reg(REG_STANCE_MIN, CFG_W'(smin));
		write_reg(REG_SWING_MIN, CFG_W'(wmin));
		write_reg(INDEX_W'($urandom_range(REG_SWING_MIN + 1, (1 << INDEX_W) - 1)),
			CFG_W'($urandom));
		cfg_valid <= 1'b0;
		cur_ab   = ab;
		cur_gb   = gb;
		cur_gr   = gr;
		cur_smin = smin;
		cur_wmin = wmin;
	endtask

	function automatic logic [CFG_W-1:0] pick_band();
		return ($urandom_range(3) == 0) ? CFG_W'($urandom) : CFG_W'($urandom_range(1, 600));
	endfunction

	// Mostly runs of one class with random content, the rest clears and raw noise.
	task automatic run_random(input int count);
		int   left;
		int   len;
		int   pick;
		logic want_stance;
		left = count;
		while (left > 0) begin
			pick = $urandom_range(99);
			if (pick < 4) begin
				send_sample(CMD_CLEAR, SAMPLE_W'($urandom), SAMPLE_W'($urandom));
				left--;
			end else if (pick < 16) begin
				send_sample(CMD_SAMPLE, SAMPLE_W'($urandom), SAMPLE_W'($urandom));
				left--;
			end else begin
				want_stance = 1'($urandom_range(1));
				len = $urandom_range(1, int'(want_stance ? cur_smin : cur_wmin) + 3);
				repeat (len) send_shaped(want_stance);
				left -= len;
			end
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		cfg_valid     = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = CMD_SAMPLE;
		steady        = 1'b0;
		cur_ab        = ACCEL_BAND_RST;
		cur_gb        = GYRO_BAND_RST;
		cur_gr        = GRAVITY_REF_RST;
		cur_smin      = STANCE_MIN_RST;
		cur_wmin      = SWING_MIN_RST;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed items under the reset settings: extremes and band edges.
		send_sample(CMD_CLEAR, '0, '0);
		probe(SAMPLE_LO, SAMPLE_LO);
		probe(SAMPLE_HI, SAMPLE_HI);
		probe(0, 0);
		probe(-1, 1);
		probe(G_RST + A_RST - 1, R_RST - 1);
		probe(G_RST + A_RST, 0);
		probe(G_RST - A_RST, 0);
		probe(G_RST, R_RST);
		probe(G_RST, -R_RST);
		// Four stance samples confirm stance; a fifth confirms it again without a transition.
		probe(G_RST - A_RST + 1, -(R_RST - 1));
		probe(G_RST, 0);
		probe(G_RST + A_RST - 1, R_RST - 1);
		probe(G_RST, 0);
		probe(G_RST, 0);
		// A swing run broken by a clear.
		probe(SAMPLE_LO, 0);
		probe(G_RST, SAMPLE_HI);
		probe(SAMPLE_HI, SAMPLE_LO);
		send_sample(CMD_CLEAR, SAMPLE_W'(SAMPLE_HI), SAMPLE_W'(SAMPLE_LO));
		probe(G_RST, 0);

		// Lowest settings: nothing can be stance and every swing confirms at once.
		load_settings('0, '0, '0, '0, '0);
		run_random(80);

		// Highest settings: runs must saturate before a phase is confirmed.
		load_settings('1, '1, '1, 8'd254, 8'd254);
		repeat (260) send_shaped(1'b1);
		repeat (260) send_shaped(1'b0);
		run_random(60);

		// Random settings, mostly with short minimums.
		repeat (6) begin
			load_settings(pick_band(), pick_band(),
				$urandom_range(1) ? CFG_W'($urandom) : CFG_W'($urandom_range(2000, 3000)),
				($urandom_range(7) == 0) ? MIN_W'($urandom_range(0, 254))
					: MIN_W'($urandom_range(0, 5)),
				($urandom_range(7) == 0) ? MIN_W'($urandom_range(0, 254))
					: MIN_W'($urandom_range(0, 5)));
			run_random(50);
		end

		// Alternating classes with zero minimums, with no idling on either side.
		load_settings(ACCEL_BAND_RST, GYRO_BAND_RST, GRAVITY_REF_RST, '0, '0);
		steady <= 1'b1;
		send_sample(CMD_CLEAR, '0, '0);
		for (int k = 0; k < 100; k++) send_shaped(k % 2 == 0);
		send_sample(CMD_CLEAR, '0, '0);
		steady <= 1'b0;

		// Back to the reset settings for a last stretch.
		load_settings(ACCEL_BAND_RST, GYRO_BAND_RST, GRAVITY_REF_RST, STANCE_MIN_RST,
			SWING_MIN_RST);
		run_random(100);

		drain();
		repeat (8) @(posedge clk);
		if (failures == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	// Guard against a hung handshake.
	initial begin
		#20ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

FILE: files.f
hw/rtl/gpq_pkg.sv
hw/rtl/gpq_classify.sv
hw/rtl/gpq_tracker.sv
hw/rtl/gait_phase_qualifier.sv
verif/gpq_checker.sv
verif/tb_gait_phase_qualifier.sv
